### rtl/tcmp_pkg.sv
// ----------------------------------------------------------------------------
// tcmp_pkg
// Shared types, constants and modular arithmetic helpers for the tiling
// count matrix power block.
// ----------------------------------------------------------------------------
package tcmp_pkg;

  localparam int DATA_W          = 30;
  localparam int ADDR_W          = 6;
  localparam int LENGTH_BITS_DEF = 31;
  localparam logic [DATA_W-1:0] MOD_P = DATA_W'(1000000007);

  typedef enum logic [1:0] {
    ADD_NONE,
    ADD_RD0,
    ADD_RD1
  } add_src_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_BIT,
    ST_RD,
    ST_START,
    ST_BUSY,
    ST_WR,
    ST_FIN_RD,
    ST_FIN_A1,
    ST_FIN_A2,
    ST_FIN_B,
    ST_FIN_C,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              load;
    logic              shift;
    logic [ADDR_W-1:0] ra0;
    logic [ADDR_W-1:0] ra1;
    logic [ADDR_W-1:0] wa;
    logic              we;
    logic              wsel_init;
    logic [1:0]        init_val;
    logic              mul_start;
    logic              clr_sum;
    add_src_e          add_src;
    logic              out_load;
  } tcmp_cmd_t;

  typedef struct packed {
    logic short_len;
    logic expo_zero;
    logic expo_lsb;
    logic mul_done;
  } tcmp_status_t;

  // Sum of two residues, reduced once.
  function automatic logic [DATA_W-1:0] mod_add(input logic [DATA_W-1:0] x,
                                                input logic [DATA_W-1:0] y);
    logic [DATA_W:0] t;
    t = {1'b0, x} + {1'b0, y};
    if (t >= {1'b0, MOD_P}) begin
      t = t - {1'b0, MOD_P};
    end
    return t[DATA_W-1:0];
  endfunction

  // One step of interleaved modular multiplication: r = 2r + bit*a mod p.
  function automatic logic [DATA_W-1:0] mod_step(input logic [DATA_W-1:0] r,
                                                 input logic              b,
                                                 input logic [DATA_W-1:0] a);
    logic [DATA_W+1:0] t;
    t = {1'b0, r, 1'b0} + (b ? {2'b00, a} : '0);
    if (t >= {2'b00, MOD_P}) begin
      t = t - {2'b00, MOD_P};
    end
    if (t >= {2'b00, MOD_P}) begin
      t = t - {2'b00, MOD_P};
    end
    return t[DATA_W-1:0];
  endfunction

endpackage

### rtl/tcmp_modmul.sv
// ----------------------------------------------------------------------------
// tcmp_modmul
// Sequential modular multiplier, two multiplier bits per cycle.
// ----------------------------------------------------------------------------
module tcmp_modmul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tcmp_pkg::DATA_W-1:0] a_i,
  input  logic [tcmp_pkg::DATA_W-1:0] b_i,
  output logic                       done_o,
  output logic [tcmp_pkg::DATA_W-1:0] prod_o
);
  import tcmp_pkg::*;

  localparam int STEPS = DATA_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic [DATA_W-1:0] a_q, b_q, b_d, r_q, r_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;

  always_comb begin
    r_d    = r_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      r_d    = '0;
      b_d    = b_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d   = mod_step(mod_step(r_q, b_q[DATA_W-1], a_q), b_q[DATA_W-2], a_q);
      b_d   = {b_q[DATA_W-3:0], 2'b00};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
    end
    r_q <= r_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = r_q;

endmodule

### rtl/tcmp_datapath.sv
// ----------------------------------------------------------------------------
// tcmp_datapath
// Matrix store, exponent register, modular multiply-accumulate and
// result register.
// ----------------------------------------------------------------------------
module tcmp_datapath #(
  parameter int LENGTH_BITS = tcmp_pkg::LENGTH_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcmp_pkg::tcmp_cmd_t         cmd_i,
  output tcmp_pkg::tcmp_status_t      status_o,
  input  logic [LENGTH_BITS-1:0]      length_i,
  output logic [tcmp_pkg::DATA_W-1:0] count_o
);
  import tcmp_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0]      mem_q [DEPTH];
  logic [DATA_W-1:0]      rd0_q, rd1_q, wdata;
  logic [LENGTH_BITS-1:0] expo_q;
  logic                   short_q;
  logic [1:0]             short_val_q;
  logic [DATA_W-1:0]      sum_q, sum_d, count_q, prod;
  logic                   mul_done;

  tcmp_modmul u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (rd0_q),
    .b_i     (rd1_q),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  assign wdata = cmd_i.wsel_init ? {{(DATA_W-2){1'b0}}, cmd_i.init_val} : sum_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[cmd_i.wa] <= wdata;
    end
    rd0_q <= mem_q[cmd_i.ra0];
    rd1_q <= mem_q[cmd_i.ra1];
  end

  always_comb begin
    sum_d = sum_q;
    if (cmd_i.clr_sum || cmd_i.load) begin
      sum_d = '0;
    end else if (mul_done) begin
      sum_d = mod_add(sum_q, prod);
    end else begin
      case (cmd_i.add_src)
        ADD_RD0: sum_d = mod_add(sum_q, rd0_q);
        ADD_RD1: sum_d = mod_add(sum_q, rd1_q);
        default: sum_d = sum_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (cmd_i.load) begin
      expo_q      <= length_i - LENGTH_BITS'(2);
      short_q     <= (length_i <= LENGTH_BITS'(2));
      short_val_q <= length_i[1:0];
    end else if (cmd_i.shift) begin
      expo_q <= expo_q >> 1;
    end
    if (cmd_i.out_load) begin
      count_q <= short_q ? {{(DATA_W-2){1'b0}}, short_val_q} : sum_q;
    end
  end

  assign status_o.short_len = short_q;
  assign status_o.expo_zero = (expo_q == '0);
  assign status_o.expo_lsb  = expo_q[0];
  assign status_o.mul_done  = mul_done;
  assign count_o            = count_q;

endmodule

### rtl/tcmp_ctrl.sv
// ----------------------------------------------------------------------------
// tcmp_ctrl
// Sequencer for matrix initialization, square-and-multiply, final sum
// and the handshakes.
// ----------------------------------------------------------------------------
module tcmp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output tcmp_pkg::tcmp_cmd_t    cmd_o,
  input  tcmp_pkg::tcmp_status_t status_i
);
  import tcmp_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [1:0] acc_b_q, acc_b_d, pw_b_q, pw_b_d, free_b_q, free_b_d;
  logic       init_pw_q, init_pw_d, sq_q, sq_d;
  logic       out_valid_q, out_valid_d;
  logic       last_ij;

  function automatic logic [1:0] base_entry(input logic [1:0] r, input logic [1:0] c);
    logic [1:0] v;
    v = 2'd0;
    case ({r, c})
      {2'd0, 2'd0}, {2'd0, 2'd1}, {2'd1, 2'd0},
      {2'd2, 2'd1}, {2'd2, 2'd2}: v = 2'd1;
      {2'd0, 2'd2}:               v = 2'd2;
      default:                    v = 2'd0;
    endcase
    return v;
  endfunction

  assign last_ij = (i_q == 2'd2) && (j_q == 2'd2);

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    acc_b_d     = acc_b_q;
    pw_b_d      = pw_b_q;
    free_b_d    = free_b_q;
    init_pw_d   = init_pw_q;
    sq_d        = sq_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.add_src = ADD_NONE;
    in_stall_o  = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          acc_b_d    = 2'd0;
          pw_b_d     = 2'd1;
          free_b_d   = 2'd2;
          i_d        = 2'd0;
          j_d        = 2'd0;
          k_d        = 2'd0;
          init_pw_d  = 1'b0;
          state_d    = ST_INIT;
        end
      end
      ST_INIT: begin
        if (status_i.short_len) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.we        = 1'b1;
          cmd_o.wsel_init = 1'b1;
          cmd_o.wa        = {init_pw_q ? pw_b_q : acc_b_q, i_q, j_q};
          cmd_o.init_val  = init_pw_q ? base_entry(i_q, j_q) : {1'b0, i_q == j_q};
          j_d = (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
          if (j_q == 2'd2) begin
            i_d = (i_q == 2'd2) ? 2'd0 : i_q + 2'd1;
          end
          if (last_ij) begin
            init_pw_d = 1'b1;
            if (init_pw_q) begin
              state_d = ST_BIT;
            end
          end
        end
      end
      ST_BIT: begin
        i_d = 2'd0;
        j_d = 2'd0;
        k_d = 2'd0;
        if (status_i.expo_zero) begin
          state_d = ST_FIN_RD;
        end else begin
          sq_d    = !status_i.expo_lsb;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.ra0 = {sq_q ? pw_b_q : acc_b_q, i_q, k_q};
        cmd_o.ra1 = {pw_b_q, k_q, j_q};
        state_d   = ST_START;
      end
      ST_START: begin
        cmd_o.mul_start = 1'b1;
        state_d         = ST_BUSY;
      end
      ST_BUSY: begin
        if (status_i.mul_done) begin
          if (k_q == 2'd2) begin
            k_d     = 2'd0;
            state_d = ST_WR;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = ST_RD;
          end
        end
      end
      ST_WR: begin
        cmd_o.we      = 1'b1;
        cmd_o.wa      = {free_b_q, i_q, j_q};
        cmd_o.clr_sum = 1'b1;
        j_d = (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
        if (j_q == 2'd2) begin
          i_d = (i_q == 2'd2) ? 2'd0 : i_q + 2'd1;
        end
        state_d = ST_RD;
        if (last_ij) begin
          // The finished product takes the place of its target matrix.
          free_b_d = sq_q ? pw_b_q : acc_b_q;
          if (sq_q) begin
            pw_b_d      = free_b_q;
            cmd_o.shift = 1'b1;
            state_d     = ST_BIT;
          end else begin
            acc_b_d = free_b_q;
            sq_d    = 1'b1;
          end
        end
      end
      ST_FIN_RD: begin
        cmd_o.ra0     = {acc_b_q, 2'd0, 2'd0};
        cmd_o.ra1     = {acc_b_q, 2'd0, 2'd1};
        cmd_o.clr_sum = 1'b1;
        state_d       = ST_FIN_A1;
      end
      ST_FIN_A1: begin
        cmd_o.ra0     = {acc_b_q, 2'd0, 2'd0};
        cmd_o.ra1     = {acc_b_q, 2'd0, 2'd1};
        cmd_o.add_src = ADD_RD0;
        state_d       = ST_FIN_A2;
      end
      ST_FIN_A2: begin
        cmd_o.ra0     = {acc_b_q, 2'd0, 2'd2};
        cmd_o.ra1     = {acc_b_q, 2'd0, 2'd1};
        cmd_o.add_src = ADD_RD0;
        state_d       = ST_FIN_B;
      end
      ST_FIN_B: begin
        cmd_o.ra0     = {acc_b_q, 2'd0, 2'd2};
        cmd_o.add_src = ADD_RD1;
        state_d       = ST_FIN_C;
      end
      ST_FIN_C: begin
        cmd_o.add_src = ADD_RD0;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      i_q         <= 2'd0;
      j_q         <= 2'd0;
      k_q         <= 2'd0;
      acc_b_q     <= 2'd0;
      pw_b_q      <= 2'd1;
      free_b_q    <= 2'd2;
      init_pw_q   <= 1'b0;
      sq_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      acc_b_q     <= acc_b_d;
      pw_b_q      <= pw_b_d;
      free_b_q    <= free_b_d;
      init_pw_q   <= init_pw_d;
      sq_q        <= sq_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/tiling_count_matrix_power_mod.sv
// Counts the tilings of a 2-by-n board by dominoes and trominoes modulo
// 1000000007. One length is taken at a time; lengths of 0, 1 and 2 return
// themselves. Longer boards load two 3x3 matrices and then run
// square-and-multiply over the bits of n-2, stopping once the remaining
// exponent is zero. All 27 element products of each matrix product go
// through a single shared modular multiplier that retires two multiplier
// bits per cycle.
// A finished count waits in an output register while the next length loads.

// ----------------------------------------------------------------------------
// tiling_count_matrix_power_mod
// Top level: controller and datapath for the tiling count matrix power.
// ----------------------------------------------------------------------------
module tiling_count_matrix_power_mod #(
  parameter int LENGTH_BITS = tcmp_pkg::LENGTH_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [LENGTH_BITS-1:0]      length_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tcmp_pkg::DATA_W-1:0] count_o
);
  import tcmp_pkg::*;

  tcmp_cmd_t    cmd;
  tcmp_status_t status;

  tcmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  tcmp_datapath #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .length_i (length_i),
    .count_o  (count_o)
  );

endmodule
